[src/stok_pkg.sv]
// Package with types, character codes and the per-byte lexer step of the shell tokenizer.
`default_nettype none
package stok_pkg;

    localparam int MAX_LINE_DEF = 4096;
    localparam int POS_W        = 12;
    localparam int MAX_ITEMS    = 4;

    typedef enum logic [3:0] {
        K_WORD    = 4'd0,
        K_VAR     = 4'd1,
        K_PIPE    = 4'd2,
        K_AND     = 4'd3,
        K_BG      = 4'd4,
        K_SEMI    = 4'd5,
        K_LESS    = 4'd6,
        K_GREATER = 4'd7,
        K_APPEND  = 4'd8,
        K_RAMP    = 4'd9,
        K_ERR     = 4'd10,
        K_ERRAPP  = 4'd11,
        K_BOTH    = 4'd12,
        K_END     = 4'd13
    } kind_t;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_AMP   = 4'd1,
        M_GT    = 4'd2,
        M_TWO   = 4'd3,
        M_TWOGT = 4'd4,
        M_DOLT  = 4'd5,
        M_VAR   = 4'd6,
        M_PCT   = 4'd7,
        M_QTOP  = 4'd8,
        M_WORD  = 4'd9,
        M_DOLW  = 4'd10,
        M_VWORD = 4'd11,
        M_QWORD = 4'd12
    } mode_t;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DQ     = 8'h22;
    localparam logic [7:0] CH_SQ     = 8'h27;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         value;
        logic               valid;
        logic               first;
        logic               fin;
        logic [POS_W-1:0]   offset;
    } item_t;

    typedef struct packed {
        mode_t              mode;
        logic               esc;
        logic               dq;
        logic               skip;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   tstart;
        kind_t              kind;
        logic               begun;
    } lex_state_t;

    typedef struct packed {
        lex_state_t         st;
        item_t [MAX_ITEMS-1:0] items;
        logic [2:0]         n;
        logic               open;
    } work_t;

    function automatic logic is_ws(logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_word_char(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A) || c == CH_USCORE;
    endfunction

    function automatic logic dollar_plain(logic [7:0] c);
        return c == CH_LPAR || c == CH_SPACE || c == CH_TAB || c == 8'd0;
    endfunction

    function automatic work_t emit_item(work_t w, logic [7:0] ch, logic valid, logic fin);
        work_t r;
        r = w;
        if (r.n < 3'(MAX_ITEMS)) begin
            r.items[r.n[1:0]].kind   = r.st.kind;
            r.items[r.n[1:0]].value  = valid ? ch : 8'd0;
            r.items[r.n[1:0]].valid  = valid;
            r.items[r.n[1:0]].first  = !r.st.begun;
            r.items[r.n[1:0]].fin    = fin;
            r.items[r.n[1:0]].offset = r.st.tstart;
            r.st.begun = 1'b1;
            r.n = r.n + 3'd1;
        end
        return r;
    endfunction

    function automatic work_t emit_char(work_t w, logic [7:0] ch);
        work_t r;
        r = emit_item(w, ch, 1'b1, 1'b0);
        r.open = 1'b1;
        return r;
    endfunction

    function automatic work_t finish_token(work_t w);
        work_t r;
        logic [1:0] li;
        r = w;
        li = 2'(r.n - 3'd1);
        if (r.open && r.n != 3'd0) begin
            r.items[li].fin = 1'b1;
        end else begin
            r = emit_item(r, 8'd0, 1'b0, 1'b1);
        end
        r.open    = 1'b0;
        r.st.mode = M_IDLE;
        r.st.skip = 1'b1;
        r.st.esc  = 1'b0;
        return r;
    endfunction

    function automatic work_t start_token(work_t w, kind_t k);
        work_t r;
        r = w;
        r.st.kind   = k;
        r.st.tstart = r.st.pos;
        r.st.begun  = 1'b0;
        r.open      = 1'b0;
        return r;
    endfunction

    // One input byte: the lexer re-examines the byte after a mode change, at most a few times.
    function automatic work_t lex_step(lex_state_t s, logic [7:0] c, logic last,
                                       logic [POS_W-1:0] pos_max);
        work_t w;
        logic go;
        logic [7:0] qc;
        logic [POS_W-1:0] len;
        w = '0;
        w.st = s;
        go = 1'b1;
        for (int i = 0; i < 6; i++) begin
            if (go) begin
                go = 1'b0;
                qc = w.st.dq ? CH_DQ : CH_SQ;
                unique case (w.st.mode)
                    M_IDLE: begin
                        if (!(is_ws(c) || (c == CH_HASH && w.st.skip))) begin
                            w = start_token(w, K_WORD);
                            if (c == CH_PIPE) begin
                                w.st.kind = K_PIPE; w = finish_token(w);
                            end else if (c == CH_SEMI) begin
                                w.st.kind = K_SEMI; w = finish_token(w);
                            end else if (c == CH_LT) begin
                                w.st.kind = K_LESS; w = finish_token(w);
                            end else if (c == CH_AMP) begin
                                w.st.mode = M_AMP;
                            end else if (c == CH_GT) begin
                                w.st.mode = M_GT;
                            end else if (c == CH_TWO) begin
                                w.st.mode = M_TWO;
                            end else if (c == CH_DOLLAR) begin
                                w.st.mode = M_DOLT;
                            end else if (c == CH_AT) begin
                                w = emit_char(w, c); w = finish_token(w);
                            end else if (c == CH_PCT) begin
                                w = emit_char(w, c); w.st.mode = M_PCT;
                            end else if (c == CH_DQ || c == CH_SQ) begin
                                w.st.dq = (c == CH_DQ); w.st.mode = M_QTOP;
                            end else begin
                                w.st.mode = M_WORD; go = 1'b1;
                            end
                        end
                    end
                    M_AMP: begin
                        if (c == CH_AMP) begin
                            w.st.kind = K_AND; w = finish_token(w);
                        end else begin
                            w.st.kind = K_BG; w = finish_token(w); go = 1'b1;
                        end
                    end
                    M_GT: begin
                        if (c == CH_GT) begin
                            w.st.kind = K_APPEND; w = finish_token(w);
                        end else if (c == CH_AMP) begin
                            w.st.kind = K_RAMP; w = finish_token(w);
                        end else begin
                            w.st.kind = K_GREATER; w = finish_token(w); go = 1'b1;
                        end
                    end
                    M_TWO: begin
                        if (c == CH_GT) begin
                            w.st.mode = M_TWOGT;
                        end else begin
                            w = emit_char(w, CH_TWO); w.st.mode = M_WORD; go = 1'b1;
                        end
                    end
                    M_TWOGT: begin
                        if (c == CH_GT) begin
                            w.st.kind = K_ERRAPP; w = finish_token(w);
                        end else if (c == CH_AMP) begin
                            w.st.kind = K_BOTH; w = finish_token(w);
                        end else begin
                            w.st.kind = K_ERR; w = finish_token(w); go = 1'b1;
                        end
                    end
                    M_DOLT: begin
                        if (dollar_plain(c)) begin
                            w = emit_char(w, CH_DOLLAR); w = finish_token(w);
                        end else begin
                            w.st.kind = K_VAR; w = emit_char(w, CH_DOLLAR);
                            w.st.mode = M_VAR;
                        end
                        go = 1'b1;
                    end
                    M_VAR: begin
                        if (is_word_char(c)) begin
                            w = emit_char(w, c);
                        end else begin
                            w = finish_token(w); go = 1'b1;
                        end
                    end
                    M_PCT: begin
                        w = emit_char(w, c);
                        if (c == CH_PCT) begin
                            w = finish_token(w);
                        end
                    end
                    M_QTOP, M_QWORD: begin
                        if (w.st.esc) begin
                            if (c != CH_DQ && c != CH_BSL) begin
                                w = emit_char(w, CH_BSL);
                            end
                            w = emit_char(w, c);
                            w.st.esc = 1'b0;
                        end else if (c == CH_BSL && w.st.dq) begin
                            w.st.esc = 1'b1;
                        end else if (c == qc) begin
                            if (w.st.mode == M_QTOP) begin
                                w = finish_token(w);
                            end else begin
                                w.st.mode = M_WORD;
                            end
                        end else begin
                            w = emit_char(w, c);
                        end
                    end
                    M_WORD: begin
                        if (w.st.esc) begin
                            w = emit_char(w, c); w.st.esc = 1'b0;
                        end else if (c == CH_BSL) begin
                            w.st.esc = 1'b1;
                        end else if (is_ws(c) || c == CH_PIPE || c == CH_AMP ||
                                     c == CH_SEMI || c == CH_LT || c == CH_GT ||
                                     c == CH_PCT) begin
                            w = finish_token(w); go = 1'b1;
                        end else if (c == CH_DQ || c == CH_SQ) begin
                            w.st.dq = (c == CH_DQ); w.st.mode = M_QWORD;
                        end else if (c == CH_DOLLAR) begin
                            w.st.mode = M_DOLW;
                        end else begin
                            w = emit_char(w, c);
                        end
                    end
                    M_DOLW: begin
                        w = emit_char(w, CH_DOLLAR);
                        w.st.mode = dollar_plain(c) ? M_WORD : M_VWORD;
                        go = 1'b1;
                    end
                    M_VWORD: begin
                        if (is_word_char(c)) begin
                            w = emit_char(w, c);
                        end else begin
                            w.st.mode = M_WORD; go = 1'b1;
                        end
                    end
                    default: begin
                        w.st.mode = M_IDLE; go = 1'b1;
                    end
                endcase
            end
        end
        if (last) begin
            unique case (w.st.mode)
                M_IDLE: ;
                M_AMP: begin w.st.kind = K_BG; w = finish_token(w); end
                M_GT: begin w.st.kind = K_GREATER; w = finish_token(w); end
                M_TWO: begin w = emit_char(w, CH_TWO); w = finish_token(w); end
                M_TWOGT: begin w.st.kind = K_ERR; w = finish_token(w); end
                M_DOLT, M_DOLW: begin w = emit_char(w, CH_DOLLAR); w = finish_token(w); end
                default: w = finish_token(w);
            endcase
            len = (w.st.pos < pos_max) ? w.st.pos + 1'b1 : pos_max;
            w = start_token(w, K_END);
            w.st.tstart = len;
            w = finish_token(w);
            w.st = '0;
            w.st.mode = M_IDLE;
            w.st.kind = K_WORD;
        end else if (w.st.pos < pos_max) begin
            w.st.pos = w.st.pos + 1'b1;
        end
        return w;
    endfunction

endpackage
`default_nettype wire

[src/shell_command_tokenizer_core.sv]
// Top level of the shell command tokenizer: byte intake, lexer state and result buffer.
//
// The block takes a command line one byte per transfer on the s_axis channel,
// with s_axis_tlast set on the last byte of the line. Each byte is lexed in
// the cycle it is accepted; the zero to four result items it causes are held
// in a result buffer and leave on the m_axis channel, one item per transfer.
// m_axis_tlast marks the last item caused by one input byte. Every line ends
// with an End token whose offset is the line length, saturated at POS_MAX.
// An accepted byte's first result item is offered in the following cycle.
// Bytes that give at most one item stream at one per cycle while the
// receiver is ready; a byte that gives several items holds the result buffer
// until the last of them leaves. A new byte is taken in the cycle the last
// buffered item leaves.
// When the receiver stalls, the buffered item holds and s_axis_tready stays
// low until it is taken. Reset (aresetn low, synchronous) empties the buffer
// and returns the lexer to the between-tokens state at line offset zero.
`default_nettype none
module shell_command_tokenizer_core #(
    parameter int MAX_LINE = stok_pkg::MAX_LINE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [3:0] token_type, [11:4] value_char, [12] char_valid, [13] token_begin,
    // [14] token_finish, [26:15] token_offset, [31:27] zero
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    import stok_pkg::*;

    localparam int POS_MAX = (MAX_LINE - 1 < 4095) ? MAX_LINE - 1 : 4095;

    lex_state_t            state_reg;
    item_t [MAX_ITEMS-1:0] items_reg;
    logic [2:0]            count_reg;
    logic [2:0]            idx_reg;
    work_t                 step_next;
    logic                  take;
    logic                  final_take;
    logic                  accept;
    item_t                 cur;

    assign step_next     = lex_step(state_reg, s_axis_tdata, s_axis_tlast, POS_W'(POS_MAX));
    assign m_axis_tvalid = idx_reg < count_reg;
    assign take          = m_axis_tvalid && m_axis_tready;
    assign final_take    = take && (idx_reg + 3'd1 == count_reg);
    assign s_axis_tready = !m_axis_tvalid || final_take;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cur           = items_reg[idx_reg[1:0]];
    assign m_axis_tlast  = (idx_reg + 3'd1 == count_reg);
    assign m_axis_tdata  = {5'd0, cur.offset, cur.fin, cur.first, cur.valid,
                            cur.value, cur.kind};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: M_IDLE, esc: 1'b0, dq: 1'b0, skip: 1'b0,
                           pos: '0, tstart: '0, kind: K_WORD, begun: 1'b0};
            count_reg <= 3'd0;
            idx_reg   <= 3'd0;
        end else if (accept) begin
            state_reg <= step_next.st;
            count_reg <= step_next.n;
            idx_reg   <= 3'd0;
        end else if (take) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            items_reg <= step_next.items;
        end
    end

endmodule
`default_nettype wire

[src/stok_checker.sv]
// Port-level checker for the shell command tokenizer and its bind statement.
`default_nettype none
module stok_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    import stok_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result transfer changed.");

    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[3:0] == K_END |->
            m_axis_tdata[13] && m_axis_tdata[14] && m_axis_tlast && !m_axis_tdata[12])
        else $error("End token is not a lone final item.");

    a_nochar: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[12] |-> m_axis_tdata[11:4] == 8'd0)
        else $error("Value character set without char_valid.");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("Result buffer not empty after reset.");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("Input taken while a result is stalled.");

endmodule

bind shell_command_tokenizer_core stok_checker u_stok_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

[verif/shell_command_tokenizer_core_tb.sv]
// Self-checking testbench for the shell tokenizer core: directed lines, then random command lines.
`timescale 1ns / 1ps
`default_nettype none
module shell_command_tokenizer_core_tb;
    import stok_pkg::*;

    localparam int POS_LIMIT = 4095;
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_BYTES = 380;

    typedef struct {
        kind_t      kind;
        logic [7:0] ch;
        logic       valid;
        logic       first;
        logic       fin;
        logic [11:0] offset;
        logic       last;
    } token_item_t;

    typedef struct {
        logic [7:0] c;
        logic       eol;
        logic       typed;
        kind_t      kind;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    shell_command_tokenizer_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    token_item_t pending_tokens[$];
    token_item_t step_items[4];
    int          step_count;
    logic        step_open;
    int          failures = 0;
    int          idle_cycles = 0;
    logic        stim_done = 1'b0;
    logic        quiet_mode = 1'b0;

    mode_t       lx_mode;
    logic        lx_esc, lx_dq, lx_skip, lx_begun;
    logic [11:0] lx_pos, lx_start;
    kind_t       lx_kind;

    function automatic logic ws_byte(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic name_byte(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
               (c >= "A" && c <= "Z") || c == CH_USCORE;
    endfunction

    function automatic logic plain_dollar(logic [7:0] c);
        return c == CH_LPAR || c == CH_SPACE || c == CH_TAB || c == 8'd0;
    endfunction

    task automatic lexer_clear();
        lx_mode = M_IDLE;
        lx_esc = 0; lx_dq = 0; lx_skip = 0; lx_begun = 0;
        lx_pos = 0; lx_start = 0; lx_kind = K_WORD;
    endtask

    task automatic add_item(logic [7:0] ch, logic valid, logic fin);
        if (step_count < 4) begin
            step_items[step_count] = '{lx_kind, valid ? ch : 8'd0, valid, !lx_begun, fin,
                                       lx_start, 1'b0};
            lx_begun = 1;
            step_count++;
        end
    endtask

    task automatic add_char(logic [7:0] ch);
        add_item(ch, 1'b1, 1'b0);
        step_open = 1;
    endtask

    task automatic close_token();
        if (step_open && step_count > 0) step_items[step_count-1].fin = 1;
        else add_item(8'd0, 1'b0, 1'b1);
        step_open = 0;
        lx_mode = M_IDLE;
        lx_skip = 1;
        lx_esc = 0;
    endtask

    task automatic open_token(kind_t k);
        lx_kind = k;
        lx_start = lx_pos;
        lx_begun = 0;
        step_open = 0;
    endtask

    task automatic lex_byte(logic [7:0] c);
        logic again;
        again = 1;
        while (again) begin
            again = 0;
            case (lx_mode)
                M_IDLE: begin
                    if (!(ws_byte(c) || (c == CH_HASH && lx_skip))) begin
                        open_token(K_WORD);
                        case (c)
                            CH_PIPE: begin lx_kind = K_PIPE; close_token(); end
                            CH_SEMI: begin lx_kind = K_SEMI; close_token(); end
                            CH_LT: begin lx_kind = K_LESS; close_token(); end
                            CH_AMP: lx_mode = M_AMP;
                            CH_GT: lx_mode = M_GT;
                            CH_TWO: lx_mode = M_TWO;
                            CH_DOLLAR: lx_mode = M_DOLT;
                            CH_AT: begin add_char(c); close_token(); end
                            CH_PCT: begin add_char(c); lx_mode = M_PCT; end
                            CH_DQ, CH_SQ: begin lx_dq = (c == CH_DQ); lx_mode = M_QTOP; end
                            default: begin lx_mode = M_WORD; again = 1; end
                        endcase
                    end
                end
                M_AMP: begin
                    if (c == CH_AMP) begin lx_kind = K_AND; close_token(); end
                    else begin lx_kind = K_BG; close_token(); again = 1; end
                end
                M_GT: begin
                    if (c == CH_GT) begin lx_kind = K_APPEND; close_token(); end
                    else if (c == CH_AMP) begin lx_kind = K_RAMP; close_token(); end
                    else begin lx_kind = K_GREATER; close_token(); again = 1; end
                end
                M_TWO: begin
                    if (c == CH_GT) lx_mode = M_TWOGT;
                    else begin add_char(CH_TWO); lx_mode = M_WORD; again = 1; end
                end
                M_TWOGT: begin
                    if (c == CH_GT) begin lx_kind = K_ERRAPP; close_token(); end
                    else if (c == CH_AMP) begin lx_kind = K_BOTH; close_token(); end
                    else begin lx_kind = K_ERR; close_token(); again = 1; end
                end
                M_DOLT: begin
                    if (plain_dollar(c)) begin add_char(CH_DOLLAR); close_token(); end
                    else begin lx_kind = K_VAR; add_char(CH_DOLLAR); lx_mode = M_VAR; end
                    again = 1;
                end
                M_VAR: begin
                    if (name_byte(c)) add_char(c);
                    else begin close_token(); again = 1; end
                end
                M_PCT: begin
                    add_char(c);
                    if (c == CH_PCT) close_token();
                end
                M_QTOP, M_QWORD: begin
                    if (lx_esc) begin
                        if (c != CH_DQ && c != CH_BSL) add_char(CH_BSL);
                        add_char(c);
                        lx_esc = 0;
                    end else if (c == CH_BSL && lx_dq) begin
                        lx_esc = 1;
                    end else if (c == (lx_dq ? CH_DQ : CH_SQ)) begin
                        if (lx_mode == M_QTOP) close_token();
                        else lx_mode = M_WORD;
                    end else begin
                        add_char(c);
                    end
                end
                M_WORD: begin
                    if (lx_esc) begin add_char(c); lx_esc = 0; end
                    else if (c == CH_BSL) lx_esc = 1;
                    else if (ws_byte(c) || c == CH_PIPE || c == CH_AMP || c == CH_SEMI ||
                             c == CH_LT || c == CH_GT || c == CH_PCT) begin
                        close_token(); again = 1;
                    end else if (c == CH_DQ || c == CH_SQ) begin
                        lx_dq = (c == CH_DQ); lx_mode = M_QWORD;
                    end else if (c == CH_DOLLAR) lx_mode = M_DOLW;
                    else add_char(c);
                end
                M_DOLW: begin
                    add_char(CH_DOLLAR);
                    lx_mode = plain_dollar(c) ? M_WORD : M_VWORD;
                    again = 1;
                end
                M_VWORD: begin
                    if (name_byte(c)) add_char(c);
                    else begin lx_mode = M_WORD; again = 1; end
                end
                default: begin lx_mode = M_IDLE; again = 1; end
            endcase
        end
    endtask

    task automatic predict_tokens(logic [7:0] c, logic eol);
        logic [11:0] len;
        step_count = 0;
        step_open = 0;
        lex_byte(c);
        if (eol) begin
            case (lx_mode)
                M_IDLE: ;
                M_AMP: begin lx_kind = K_BG; close_token(); end
                M_GT: begin lx_kind = K_GREATER; close_token(); end
                M_TWO: begin add_char(CH_TWO); close_token(); end
                M_TWOGT: begin lx_kind = K_ERR; close_token(); end
                M_DOLT, M_DOLW: begin add_char(CH_DOLLAR); close_token(); end
                default: close_token();
            endcase
            len = (lx_pos < POS_LIMIT) ? lx_pos + 12'd1 : 12'(POS_LIMIT);
            open_token(K_END);
            lx_start = len;
            close_token();
            lexer_clear();
        end else if (lx_pos < POS_LIMIT) begin
            lx_pos++;
        end
        if (step_count > 0) step_items[step_count-1].last = 1;
        for (int i = 0; i < step_count; i++)
            pending_tokens.insert(pending_tokens.size(), step_items[i]);
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        aresetn = 0;
        lexer_clear();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
    end

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) predict_tokens(s_axis_tdata, s_axis_tlast);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected transfer, actual %h last %b", $time,
                         m_axis_tdata, m_axis_tlast);
                failures++;
            end else begin
                token_item_t e;
                logic [31:0] x;
                e = pending_tokens.pop_front();
                x = {5'd0, e.offset, e.fin, e.first, e.valid, e.ch, e.kind};
                if (m_axis_tdata !== x || m_axis_tlast !== e.last) begin
                    $display("%0t: mismatch, expected %h last %b, actual %h last %b", $time,
                             x, e.last, m_axis_tdata, m_axis_tlast);
                    failures++;
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else if (aresetn && !(stim_done && pending_tokens.size() == 0))
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        m_axis_tready = 0;
        @(posedge aresetn);
        forever begin
            int g;
            @(negedge aclk);
            g = gap_length();
            if (g > 0) begin
                m_axis_tready = 0;
                repeat (g - 1) @(negedge aclk);
            end else begin
                m_axis_tready = 1;
            end
        end
    end

    task automatic send_byte(logic [7:0] c, logic eol);
        int g;
        g = gap_length();
        if (g > 0) begin
            s_axis_tvalid = 0;
            repeat (g) @(negedge aclk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata = c;
        s_axis_tlast = eol;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic append_byte(ref logic [7:0] line[$], input logic [7:0] b);
        line.insert(line.size(), b);
    endtask

    task automatic add_text(ref logic [7:0] line[$], input string s);
        for (int i = 0; i < s.len(); i++) append_byte(line, s[i]);
    endtask

    task automatic add_fragment(ref logic [7:0] line[$]);
        string alnum;
        alnum = "abcXYZ019_q";
        case ($urandom_range(0, 15))
            0, 1: repeat ($urandom_range(1, 4)) append_byte(line, alnum[$urandom_range(0, 10)]);
            2, 3: append_byte(line, $urandom_range(0, 1) ? " " : 8'd9);
            4: begin
                string ops[11];
                ops = '{"|", "&&", "&", ";", "<", ">", ">>", ">&", "2>", "2>>", "2>&"};
                add_text(line, ops[$urandom_range(0, 10)]);
            end
            5: add_text(line, $urandom_range(0, 1) ? "$HOME" : "$(");
            6: add_text(line, "\"a\\\"b\\\\c\\n\"");
            7: add_text(line, $urandom_range(0, 1) ? "'x y'" : "\"\"");
            8: add_text(line, "%pa%");
            9: append_byte(line, CH_HASH);
            10: add_text(line, $urandom_range(0, 1) ? "a\\ b" : "x$y1.");
            11: add_text(line, "w\"q s\"t");
            12: add_text(line, $urandom_range(0, 1) ? "@" : "2x");
            13: append_byte(line, 8'($urandom_range(0, 255)));
            14: append_byte(line, $urandom_range(0, 1) ? CH_BSL : CH_DOLLAR);
            default: append_byte(line, 8'($urandom_range(128, 255)));
        endcase
    endtask

    stim_row_t directed[] = '{
        '{"|", 1, 1, K_PIPE},
        '{"&", 0, 0, K_WORD}, '{"&", 1, 1, K_AND},
        '{">", 0, 0, K_WORD}, '{">", 1, 1, K_APPEND},
        '{">", 0, 0, K_WORD}, '{"&", 1, 1, K_RAMP},
        '{"2", 0, 0, K_WORD}, '{">", 0, 0, K_WORD}, '{"&", 1, 1, K_BOTH},
        '{"2", 0, 0, K_WORD}, '{">", 0, 0, K_WORD}, '{">", 1, 1, K_ERRAPP},
        '{"2", 0, 0, K_WORD}, '{">", 1, 1, K_ERR},
        '{"&", 1, 1, K_BG},
        '{"$", 1, 0, K_WORD},
        '{"x", 0, 0, K_WORD}, '{"\\", 1, 1, K_WORD},
        '{8'hFF, 0, 0, K_WORD}, '{8'h00, 1, 1, K_WORD},
        '{"\"", 0, 0, K_WORD}, '{"a", 1, 0, K_WORD},
        '{"%", 0, 0, K_WORD}, '{"p", 1, 0, K_WORD},
        '{"a", 0, 0, K_WORD}, '{" ", 0, 0, K_WORD}, '{"#", 0, 0, K_WORD},
        '{" ", 0, 0, K_WORD}, '{";", 1, 1, K_SEMI},
        '{"<", 1, 1, K_LESS}
    };

    initial begin
        int sent;
        logic [7:0] line[$];
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        @(posedge aresetn);
        @(negedge aclk);
        foreach (directed[i]) begin
            send_byte(directed[i].c, directed[i].eol);
            if (directed[i].typed && step_count > 0 && step_items[0].kind != directed[i].kind) begin
                $display("%0t: table row %0d, expected kind %0d, actual predicted %0d",
                         $time, i, directed[i].kind, step_items[0].kind);
                failures++;
            end
        end
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            line.delete();
            quiet_mode = ($urandom_range(0, 5) == 0);
            repeat ($urandom_range(1, 10)) add_fragment(line);
            foreach (line[i]) send_byte(line[i], i == line.size() - 1);
            sent += line.size();
        end
        s_axis_tvalid = 0;
        stim_done = 1;
        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (failures == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
src/stok_pkg.sv
src/shell_command_tokenizer_core.sv
src/stok_checker.sv
verif/shell_command_tokenizer_core_tb.sv
